/* hdl/sha0_pkg.sv */
// shared types and constants for the sha-0 hash engine
package sha0_pkg;

    // request payloads
    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  valid_bytes;
        logic        last;
    } t_in_req;

    typedef struct packed {
        logic [31:0] digest_word;
        logic        digest_last;
    } t_out_req;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_IN_BYTE,
        S_PAD80,
        S_PADZ,
        S_PADLEN,
        S_ROUND,
        S_FINISH,
        S_EMIT
    } t_state;

    // datapath operations
    typedef enum logic [2:0] {
        DP_NOP,
        DP_LOAD,
        DP_WORD,
        DP_BYTE,
        DP_ROUND,
        DP_FINISH,
        DP_INIT
    } t_dp_op;

    // byte sources for single byte writes
    typedef enum logic [1:0] {
        BS_IN,
        BS_80,
        BS_ZERO,
        BS_LEN
    } t_byte_src;

    typedef struct packed {
        t_dp_op      op;
        t_byte_src   src;
        logic [2:0]  sel;
        logic [6:0]  rnd;
        logic [2:0]  out_idx;
    } t_dp_cmd;

    typedef struct packed {
        logic [5:0] pos;
    } t_dp_sts;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hefcdab89;
    localparam logic [31:0] H2 = 32'h98badcfe;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hc3d2e1f0;
    localparam logic [31:0] K0 = 32'h5a827999;
    localparam logic [31:0] K1 = 32'h6ed9eba1;
    localparam logic [31:0] K2 = 32'h8f1bbcdc;
    localparam logic [31:0] K3 = 32'hca62c1d6;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [5:0]  LEN_POS = 6'd56;
    localparam logic [5:0]  LAST_POS = 6'd63;
    localparam logic [6:0]  LAST_RND = 7'd79;
    localparam logic [2:0]  LAST_LEN_IDX = 3'd7;
    localparam logic [2:0]  LAST_OUT_IDX = 3'd4;
    localparam logic [2:0]  FULL_BYTES = 3'd4;

endpackage

/* hdl/sha0_dpath.sv */
// sha-0 datapath: block buffer, byte counter, round logic and chaining words
module sha0_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sha0_pkg::t_dp_cmd i_cmd,
    input  sha0_pkg::t_in_req i_in,
    output sha0_pkg::t_dp_sts o_sts,
    output logic [31:0]       o_digest
);
    import sha0_pkg::*;

    logic [31:0] r_chain [5];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] r_w [16];
    logic [60:0] r_cnt;
    logic [63:0] r_len;
    logic [31:0] r_word;

    logic [5:0]  pos;
    logic [7:0]  wr_byte;
    logic [31:0] s_a, s_b, s_c, s_d, s_e;
    logic [31:0] f, k, tmp, w_new;

    assign pos = r_cnt[5:0];
    assign o_sts.pos = pos;
    assign o_digest = r_chain[i_cmd.out_idx];

    // byte to write
    always_comb begin
        case (i_cmd.src)
            BS_IN: begin
                case (i_cmd.sel[1:0])
                    2'd0: wr_byte = r_word[31:24];
                    2'd1: wr_byte = r_word[23:16];
                    2'd2: wr_byte = r_word[15:8];
                    default: wr_byte = r_word[7:0];
                endcase
            end
            BS_80:   wr_byte = PAD_BYTE;
            BS_LEN:  wr_byte = r_len[8*(3'd7 - i_cmd.sel) +: 8];
            default: wr_byte = 8'h00;
        endcase
    end

    // round function, first round starts from the chaining words
    always_comb begin
        if (i_cmd.rnd == 7'd0) begin
            s_a = r_chain[0]; s_b = r_chain[1]; s_c = r_chain[2];
            s_d = r_chain[3]; s_e = r_chain[4];
        end else begin
            s_a = r_a; s_b = r_b; s_c = r_c; s_d = r_d; s_e = r_e;
        end
        if (i_cmd.rnd < 7'd20) begin
            f = (s_b & s_c) | (~s_b & s_d);
            k = K0;
        end else if (i_cmd.rnd < 7'd40) begin
            f = s_b ^ s_c ^ s_d;
            k = K1;
        end else if (i_cmd.rnd < 7'd60) begin
            f = (s_b & s_c) | (s_b & s_d) | (s_c & s_d);
            k = K2;
        end else begin
            f = s_b ^ s_c ^ s_d;
            k = K3;
        end
        tmp = {s_a[26:0], s_a[31:27]} + f + s_e + r_w[0] + k;
        w_new = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
    end

    // control-side registers: chaining words and byte count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain[0] <= H0; r_chain[1] <= H1; r_chain[2] <= H2;
            r_chain[3] <= H3; r_chain[4] <= H4;
            r_cnt <= '0;
        end else begin
            case (i_cmd.op)
                DP_WORD: r_cnt <= r_cnt + 61'd4;
                DP_BYTE: r_cnt <= r_cnt + 61'd1;
                DP_FINISH: begin
                    r_chain[0] <= r_chain[0] + r_a;
                    r_chain[1] <= r_chain[1] + r_b;
                    r_chain[2] <= r_chain[2] + r_c;
                    r_chain[3] <= r_chain[3] + r_d;
                    r_chain[4] <= r_chain[4] + r_e;
                end
                DP_INIT: begin
                    r_chain[0] <= H0; r_chain[1] <= H1; r_chain[2] <= H2;
                    r_chain[3] <= H3; r_chain[4] <= H4;
                    r_cnt <= '0;
                end
                default: ;
            endcase
        end
    end

    // payload registers: buffer, working words, captured word and length
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LOAD: r_word <= i_in.data_word;
            DP_WORD: r_w[pos[5:2]] <= i_in.data_word;
            DP_BYTE: begin
                r_w[pos[5:2]][8*(2'd3 - pos[1:0]) +: 8] <= wr_byte;
                if (i_cmd.src == BS_80) r_len <= {r_cnt, 3'b000};
            end
            DP_ROUND: begin
                r_e <= s_d;
                r_d <= s_c;
                r_c <= {s_b[1:0], s_b[31:2]};
                r_b <= s_a;
                r_a <= tmp;
                for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                r_w[15] <= w_new;
            end
            default: ;
        endcase
    end

endmodule

/* hdl/sha0_ctrl.sv */
// sha-0 controller: sequences byte writes, padding, rounds and digest output
module sha0_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  sha0_pkg::t_in_req i_in,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_digest_last,
    input  sha0_pkg::t_dp_sts i_sts,
    output sha0_pkg::t_dp_cmd o_cmd
);
    import sha0_pkg::*;

    t_state     r_state, n_state, r_ret, n_ret;
    logic [2:0] r_bidx, n_bidx, r_nb, n_nb, r_lidx, n_lidx, r_oidx, n_oidx;
    logic [6:0] r_rnd, n_rnd;
    logic       r_last, n_last;
    logic [2:0] nb;
    logic       accept;
    logic       block_end;

    assign accept = i_valid && (r_state == S_IDLE);
    assign nb = (i_in.valid_bytes > FULL_BYTES) ? FULL_BYTES : i_in.valid_bytes;
    assign block_end = (i_sts.pos == LAST_POS);

    // next state
    always_comb begin
        n_state = r_state; n_ret = r_ret; n_bidx = r_bidx; n_nb = r_nb;
        n_lidx = r_lidx; n_oidx = r_oidx; n_rnd = r_rnd; n_last = r_last;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_last = i_in.last;
                    n_nb = nb;
                    n_bidx = 3'd0;
                    if (i_sts.pos[1:0] == 2'd0 && nb == FULL_BYTES) begin
                        if (i_sts.pos[5:2] == 4'd15) begin
                            n_state = S_ROUND;
                            n_rnd = 7'd0;
                            n_ret = i_in.last ? S_PAD80 : S_IDLE;
                        end else begin
                            n_state = i_in.last ? S_PAD80 : S_IDLE;
                        end
                    end else begin
                        n_state = S_IN_BYTE;
                    end
                end
            end
            S_IN_BYTE: begin
                if (r_bidx == r_nb) begin
                    n_state = r_last ? S_PAD80 : S_IDLE;
                end else begin
                    n_bidx = r_bidx + 3'd1;
                    if (block_end) begin
                        n_state = S_ROUND; n_rnd = 7'd0; n_ret = S_IN_BYTE;
                    end
                end
            end
            S_PAD80: begin
                n_state = block_end ? S_ROUND : S_PADZ;
                n_rnd = 7'd0;
                n_ret = S_PADZ;
            end
            S_PADZ: begin
                if (i_sts.pos == LEN_POS) begin
                    n_state = S_PADLEN;
                    n_lidx = 3'd0;
                end else if (block_end) begin
                    n_state = S_ROUND; n_rnd = 7'd0; n_ret = S_PADZ;
                end
            end
            S_PADLEN: begin
                n_lidx = r_lidx + 3'd1;
                if (r_lidx == LAST_LEN_IDX) begin
                    n_state = S_ROUND; n_rnd = 7'd0; n_ret = S_EMIT;
                    n_oidx = 3'd0;
                end
            end
            S_ROUND: begin
                n_rnd = r_rnd + 7'd1;
                if (r_rnd == LAST_RND) n_state = S_FINISH;
            end
            S_FINISH: n_state = r_ret;
            S_EMIT: begin
                if (!i_stall) begin
                    n_oidx = r_oidx + 3'd1;
                    if (r_oidx == LAST_OUT_IDX) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and datapath commands
    always_comb begin
        o_cmd.op = DP_NOP;
        o_cmd.src = BS_IN;
        o_cmd.sel = r_bidx;
        o_cmd.rnd = r_rnd;
        o_cmd.out_idx = r_oidx;
        o_stall = (r_state != S_IDLE);
        o_valid = (r_state == S_EMIT);
        o_digest_last = (r_oidx == LAST_OUT_IDX);
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.op = (i_sts.pos[1:0] == 2'd0 && nb == FULL_BYTES) ? DP_WORD
                                                                          : DP_LOAD;
                end
            end
            S_IN_BYTE: if (r_bidx != r_nb) o_cmd.op = DP_BYTE;
            S_PAD80: begin
                o_cmd.op = DP_BYTE;
                o_cmd.src = BS_80;
            end
            S_PADZ: begin
                if (i_sts.pos != LEN_POS) begin
                    o_cmd.op = DP_BYTE;
                    o_cmd.src = BS_ZERO;
                end
            end
            S_PADLEN: begin
                o_cmd.op = DP_BYTE;
                o_cmd.src = BS_LEN;
                o_cmd.sel = r_lidx;
            end
            S_ROUND: o_cmd.op = DP_ROUND;
            S_FINISH: o_cmd.op = DP_FINISH;
            S_EMIT: if (!i_stall && r_oidx == LAST_OUT_IDX) o_cmd.op = DP_INIT;
            default: ;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret <= S_IDLE;
            r_bidx <= '0; r_nb <= '0; r_lidx <= '0; r_oidx <= '0;
            r_rnd <= '0; r_last <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret <= n_ret;
            r_bidx <= n_bidx; r_nb <= n_nb; r_lidx <= n_lidx; r_oidx <= n_oidx;
            r_rnd <= n_rnd; r_last <= n_last;
        end
    end

endmodule

/* hdl/sha0_hash_engine_unit.sv */
// sha-0 hash engine top level
//
// input channel: i_valid / o_stall carry one message word per request,
// big-endian, with its count of leading valid bytes and a last flag.
// output channel: o_valid / i_stall carry the five digest words A..E,
// digest_last set on the fifth.
// timing: a full, word-aligned word is written straight into the buffer;
// a short or misaligned word is captured, then written byte by byte.
// each filled 64-byte block is compressed by the single round unit and
// then added into the chaining words. the last word adds the padding
// bytes (9 to 72) and one or two compressions, then the digest words
// are offered one per cycle while the receiver does not stall.
// the block takes no request while it is busy or while digest words are
// pending; a stalled receiver simply holds the current digest word.
// reset (synchronous, active low) restores the initial chaining words and
// clears the byte count; the block is ready on the next cycle.
module sha0_hash_engine_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  sha0_pkg::t_in_req  i_data,
    output logic               o_stall,
    output logic               o_valid,
    output sha0_pkg::t_out_req o_data,
    input  logic               i_stall
);
    import sha0_pkg::*;

    t_dp_cmd     cmd;
    t_dp_sts     sts;
    logic [31:0] digest;
    logic        digest_last;

    sha0_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_in          (i_data),
        .o_stall       (o_stall),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_digest_last (digest_last),
        .i_sts         (sts),
        .o_cmd         (cmd)
    );

    sha0_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_in     (i_data),
        .o_sts    (sts),
        .o_digest (digest)
    );

    assign o_data.digest_word = digest;
    assign o_data.digest_last = digest_last;

    // no new request while a digest is pending
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("request taken during digest output");

    // a last word always keeps the input closed next cycle
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_data.last) |=> o_stall)
        else $error("input reopened after last word");

    // final digest word ends the output burst
    a_burst_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_data.digest_last) |=> !o_valid)
        else $error("output continued after final digest word");

endmodule
